### rtl/pge_pkg.sv
// ----------------------------------------------------------------------------
// pge_pkg
// Shared types and constants of the probabilistic gate evaluator.
// ----------------------------------------------------------------------------
package pge_pkg;

    localparam int SIDE_W   = 4;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int TABLE_N  = 1 << ADDR_W;
    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 12;
    localparam int RND_W    = 32;
    localparam int CNT_W    = 3;
    localparam int MAP_W    = 16;
    localparam int NODE_W   = 4;
    localparam int MASK_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAP   = 3'd4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARGMAX,
        ST_SUM,
        ST_MOD,
        ST_PICK
    } t_state;

endpackage

### rtl/pge_ram.sv
// ----------------------------------------------------------------------------
// pge_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pge_mod.sv
// ----------------------------------------------------------------------------
// pge_mod
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pge_mod
    import pge_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [SUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(RND_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_dvd;
    logic [SUM_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic [SUM_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[RND_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[SUM_W-1:0];
        end else begin
            n_rem = trial[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running division");
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step != '0) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("division restarted while running");
`endif

endmodule

### rtl/probabilistic_gate_evaluator.sv
// ----------------------------------------------------------------------------
// probabilistic_gate_evaluator
// Markov-brain style logic gate over a 16 x 16 table of weight bytes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// command   in         start high while busy low      i_mode .. i_random_value
// result    out        o_done one-cycle strobe        o_chosen_column, o_set_mask
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load word is written straight into the table and the block stays ready.
// A deterministic evaluate walks 2^outputs table entries.
// A weighted evaluate walks the row twice and runs a bit-serial remainder over
// the 32-bit random value. Reset clears the table valid bits, the state and the
// configuration registers.
// Results cannot be held off, so each result word is a single-cycle strobe.
// ----------------------------------------------------------------------------
module probabilistic_gate_evaluator
    import pge_pkg::*;
#(
    parameter int NODE_COUNT     = 16,
    parameter int MAX_GATE_PORTS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [SIDE_W-1:0]    i_row,
    input  logic [SIDE_W-1:0]    i_column,
    input  logic [WEIGHT_W-1:0]  i_weight_byte,
    input  logic [MASK_W-1:0]    i_node_states,
    input  logic [RND_W-1:0]     i_random_value,
    output logic                 o_done,
    output logic [SIDE_W-1:0]    o_chosen_column,
    output logic [MASK_W-1:0]    o_set_mask,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    function automatic logic [CNT_W-1:0] clamp_ports(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        res = cnt;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (int'(cnt) > MAX_GATE_PORTS) begin
            res = CNT_W'(MAX_GATE_PORTS);
        end
        return res;
    endfunction

    function automatic logic node_ok(input logic [NODE_W-1:0] node);
        return int'(node) < NODE_COUNT;
    endfunction

    logic [CNT_W-1:0]  r_in_count;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_det;
    logic [MAP_W-1:0]  r_in_map;
    logic [MAP_W-1:0]  r_out_map;

    t_state            r_state, n_state;
    logic [SIDE_W:0]   r_col, n_col;
    logic              r_rd_vld;
    logic [SIDE_W-1:0] r_rd_col;
    logic              r_vbit;
    logic [SIDE_W-1:0] r_row, n_row;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [WEIGHT_W-1:0] r_best, n_best;
    logic [SIDE_W-1:0] r_pick, n_pick;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_r, n_r;
    logic              r_done, n_done;
    logic [SIDE_W-1:0] r_out_col, n_out_col;
    logic [MASK_W-1:0] r_out_mask, n_out_mask;
    logic [TABLE_N-1:0] r_valid;

    logic [CNT_W-1:0]  nin;
    logic [CNT_W-1:0]  nout;
    logic [SIDE_W:0]   cols;
    logic [SIDE_W-1:0] last_col;
    logic              accept;
    logic              load_we;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
    logic [WEIGHT_W-1:0] ram_q;
    logic [WEIGHT_W-1:0] raw;
    logic [WEIGHT_W-1:0] wgt;
    logic [SUM_W-1:0]  sum_nx;
    logic              div_start;
    logic [SUM_W-1:0]  div_divisor;
    logic              div_done;
    logic [SUM_W-1:0]  div_rem;
    logic [SIDE_W-1:0] row_idx;
    logic              fin;
    logic [SIDE_W-1:0] fin_pick;
    logic [NODE_W-1:0] node;

    assign nin      = clamp_ports(r_in_count);
    assign nout     = clamp_ports(r_out_count);
    assign cols     = (SIDE_W+1)'(1) << nout;
    assign last_col = SIDE_W'(cols - 1'b1);
    assign accept   = start && !busy;
    assign load_we  = accept && (i_mode == MODE_LOAD);
    assign busy     = (r_state != ST_IDLE);
    assign issue    = (r_state == ST_ARGMAX || r_state == ST_SUM || r_state == ST_PICK)
                      && (r_col < cols);
    assign rd_addr  = {r_row, r_col[SIDE_W-1:0]};
    assign raw      = r_vbit ? ram_q : '0;
    assign wgt      = (raw == '0) ? WEIGHT_W'(1) : raw;
    assign sum_nx   = r_sum + SUM_W'(wgt);
    assign div_divisor = sum_nx - 1'b1;

    pge_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (TABLE_N)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr ({i_row, i_column}),
        .i_wdata (i_weight_byte),
        .i_re    (issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    pge_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rnd),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        row_idx = '0;
        for (int i = 0; i < 4; i++) begin
            node = r_in_map[4*i +: NODE_W];
            if (i < int'(nin)) begin
                row_idx = {row_idx[SIDE_W-2:0], node_ok(node) && i_node_states[node]};
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_rnd      = r_rnd;
        n_best     = r_best;
        n_pick     = r_pick;
        n_sum      = r_sum;
        n_r        = r_r;
        n_done     = 1'b0;
        n_out_col  = r_out_col;
        n_out_mask = r_out_mask;
        div_start  = 1'b0;
        fin        = 1'b0;
        fin_pick   = r_pick;
        if (issue) begin
            n_col = r_col + 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept && i_mode == MODE_EVAL) begin
                    n_row  = row_idx;
                    n_rnd  = i_random_value;
                    n_col  = '0;
                    n_best = '0;
                    n_pick = '0;
                    n_sum  = '0;
                    n_state = r_det ? ST_ARGMAX : ST_SUM;
                end
            end
            ST_ARGMAX: begin
                if (r_rd_vld) begin
                    if (raw > r_best) begin
                        n_best   = raw;
                        n_pick   = r_rd_col;
                        fin_pick = r_rd_col;
                    end
                    if (r_rd_col == last_col) begin
                        fin = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                if (r_rd_vld) begin
                    n_sum = sum_nx;
                    if (r_rd_col == last_col) begin
                        div_start = 1'b1;
                        n_state   = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    n_r     = div_rem + 1'b1;
                    n_col   = '0;
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (r_rd_vld) begin
                    if (r_r <= SUM_W'(wgt)) begin
                        fin_pick = r_rd_col;
                        fin      = 1'b1;
                    end else begin
                        n_r = r_r - SUM_W'(wgt);
                        if (r_rd_col == last_col) begin
                            fin_pick = last_col;
                            fin      = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fin) begin
            n_state    = ST_IDLE;
            n_done     = 1'b1;
            n_out_col  = fin_pick;
            n_out_mask = '0;
            for (int i = 0; i < 4; i++) begin
                if (i < int'(nout) && node_ok(r_out_map[4*i +: NODE_W]) && fin_pick[2'(i)]) begin
                    n_out_mask[r_out_map[4*i +: NODE_W]] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_done   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_done   <= n_done;
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_rnd      <= n_rnd;
        r_best     <= n_best;
        r_pick     <= n_pick;
        r_sum      <= n_sum;
        r_r        <= n_r;
        r_out_col  <= n_out_col;
        r_out_mask <= n_out_mask;
        if (issue) begin
            r_rd_col <= r_col[SIDE_W-1:0];
            r_vbit   <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (load_we) begin
            r_valid[{i_row, i_column}] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= CNT_W'(1);
            r_out_count <= CNT_W'(1);
            r_det       <= 1'b0;
            r_in_map    <= '0;
            r_out_map   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INPUT_COUNT:  r_in_count  <= i_cfg_data[CNT_W-1:0];
                CFG_OUTPUT_COUNT: r_out_count <= i_cfg_data[CNT_W-1:0];
                CFG_DET_MODE:     r_det       <= i_cfg_data[0];
                CFG_INPUT_MAP:    r_in_map    <= i_cfg_data[MAP_W-1:0];
                CFG_OUTPUT_MAP:   r_out_map   <= i_cfg_data[MAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_done          = r_done;
    assign o_chosen_column = r_out_col;
    assign o_set_mask      = r_out_mask;

`ifndef ASSERT_OFF
    a_done_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == ST_ARGMAX || $past(r_state) == ST_PICK))
        else $error("result word without a finished walk");
    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_EVAL) |=> busy)
        else $error("evaluate word did not start the sequencer");
    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == MODE_LOAD) |=> !busy)
        else $error("load word left the block busy");
    a_pick_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PICK) |-> (r_r != '0))
        else $error("roulette position reached zero");
`endif

endmodule

### verif/probabilistic_gate_evaluator_test.sv
// ----------------------------------------------------------------------------
// probabilistic_gate_evaluator_test
// Self-checking testbench of the probabilistic gate evaluator. Directed tests
// cover reset defaults, port saturation, argmax and weighted picks, node
// mapping and spare register indexes. A long random run follows with random
// tables, settings and idle gaps. Every result is checked against a
// behavioral copy of the gate.
// ----------------------------------------------------------------------------
module probabilistic_gate_evaluator_test;
    import pge_pkg::*;

    localparam int NODES         = 16;
    localparam int PORTS         = 4;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SPARE = CFG_OUTPUT_MAP + 3'd1;

    typedef struct packed {
        logic [SIDE_W-1:0] column;
        logic [MASK_W-1:0] mask;
    } t_gate_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_mode = MODE_LOAD;
    logic [SIDE_W-1:0]    i_row = '0;
    logic [SIDE_W-1:0]    i_column = '0;
    logic [WEIGHT_W-1:0]  i_weight_byte = '0;
    logic [MASK_W-1:0]    i_node_states = '0;
    logic [RND_W-1:0]     i_random_value = '0;
    logic                 o_done;
    logic [SIDE_W-1:0]    o_chosen_column;
    logic [MASK_W-1:0]    o_set_mask;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    logic [WEIGHT_W-1:0] weight_copy [TABLE_N] = '{default: '0};
    logic [CNT_W-1:0]    input_count_copy = 3'd1;
    logic [CNT_W-1:0]    output_count_copy = 3'd1;
    logic                det_mode_copy = 1'b0;
    logic [MAP_W-1:0]    input_map_copy = '0;
    logic [MAP_W-1:0]    output_map_copy = '0;

    t_gate_result expected_results [$];
    int error_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int gap_style = 1;

    probabilistic_gate_evaluator #(
        .NODE_COUNT    (NODES),
        .MAX_GATE_PORTS(PORTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_weight_byte  (i_weight_byte),
        .i_node_states  (i_node_states),
        .i_random_value (i_random_value),
        .o_done         (o_done),
        .o_chosen_column(o_chosen_column),
        .o_set_mask     (o_set_mask),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned ports_used(input logic [CNT_W-1:0] count);
        if (count == '0) begin
            return 1;
        end
        if (32'(count) > PORTS) begin
            return PORTS;
        end
        return 32'(count);
    endfunction

    function automatic t_gate_result predict_gate(input logic [MASK_W-1:0] states,
                                                  input logic [RND_W-1:0] rnd);
        int unsigned n_in, n_out, cols, row_sel, node, w, total, r, best, pick;
        t_gate_result res;
        n_in = ports_used(input_count_copy);
        n_out = ports_used(output_count_copy);
        cols = 1 << n_out;
        row_sel = 0;
        for (int i = 0; i < n_in; i++) begin
            node = 32'(input_map_copy[NODE_W*i +: NODE_W]);
            row_sel = (row_sel << 1) | ((node < NODES) ? 32'(states[NODE_W'(node)]) : 0);
        end
        row_sel = row_sel << SIDE_W;
        pick = 0;
        if (det_mode_copy) begin
            best = 0;
            for (int i = 0; i < cols; i++) begin
                w = 32'(weight_copy[ADDR_W'(row_sel + i)]);
                if (w > best) begin
                    best = w;
                    pick = i;
                end
            end
        end else begin
            total = 0;
            for (int i = 0; i < cols; i++) begin
                w = 32'(weight_copy[ADDR_W'(row_sel + i)]);
                total += (w == 0) ? 1 : w;
            end
            r = 1 + rnd % (total - 1);
            pick = cols - 1;
            for (int i = 0; i < cols; i++) begin
                w = 32'(weight_copy[ADDR_W'(row_sel + i)]);
                if (w == 0) begin
                    w = 1;
                end
                if (r <= w) begin
                    pick = i;
                    break;
                end
                r -= w;
            end
        end
        res.column = pick[SIDE_W-1:0];
        res.mask = '0;
        for (int i = 0; i < n_out; i++) begin
            node = 32'(output_map_copy[NODE_W*i +: NODE_W]);
            if (node < NODES && ((pick >> i) & 1) != 0) begin
                res.mask[NODE_W'(node)] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int draw_gap();
        case (gap_style)
            0: return 0;
            1: return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    task automatic send_word(input logic mode, input logic [SIDE_W-1:0] row,
                             input logic [SIDE_W-1:0] col, input logic [WEIGHT_W-1:0] wbyte,
                             input logic [MASK_W-1:0] states, input logic [RND_W-1:0] rnd);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_row <= row;
        i_column <= col;
        i_weight_byte <= wbyte;
        i_node_states <= states;
        i_random_value <= rnd;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (mode == MODE_LOAD) begin
            weight_copy[{row, col}] = wbyte;
        end else begin
            expected_results.push_back(predict_gate(states, rnd));
        end
    endtask

    task automatic load_byte(input logic [SIDE_W-1:0] row, input logic [SIDE_W-1:0] col,
                             input logic [WEIGHT_W-1:0] wbyte);
        send_word(MODE_LOAD, row, col, wbyte, MASK_W'($urandom), $urandom);
    endtask

    task automatic evaluate(input logic [MASK_W-1:0] states, input logic [RND_W-1:0] rnd);
        send_word(MODE_EVAL, SIDE_W'($urandom), SIDE_W'($urandom), WEIGHT_W'($urandom),
                  states, rnd);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_INPUT_COUNT:  input_count_copy = data[CNT_W-1:0];
            CFG_OUTPUT_COUNT: output_count_copy = data[CNT_W-1:0];
            CFG_DET_MODE:     det_mode_copy = data[0];
            CFG_INPUT_MAP:    input_map_copy = data[MAP_W-1:0];
            CFG_OUTPUT_MAP:   output_map_copy = data[MAP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        evaluate(16'h0000, 32'h0000_0000);
        evaluate(16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_port_saturation();
        settle();
        write_reg(CFG_INPUT_COUNT, 16'hFFF8);
        write_reg(CFG_OUTPUT_COUNT, 16'h0007);
        load_byte(4'd0, 4'd15, 8'd255);
        load_byte(4'd0, 4'd0, 8'd0);
        evaluate(16'h0000, 32'hFFFF_FFFF);
        settle();
        write_reg(CFG_INPUT_COUNT, 16'h0007);
        write_reg(CFG_OUTPUT_COUNT, 16'h0000);
        evaluate(16'hFFFF, 32'h8000_0001);
    endtask

    task automatic test_deterministic_pick();
        settle();
        write_reg(CFG_INPUT_COUNT, 16'h0001);
        write_reg(CFG_OUTPUT_COUNT, 16'h0004);
        write_reg(CFG_DET_MODE, 16'hFFFF);
        write_reg(CFG_INPUT_MAP, 16'h0000);
        write_reg(CFG_OUTPUT_MAP, 16'h3210);
        evaluate(16'h0000, $urandom);
        load_byte(4'd1, 4'd3, 8'd200);
        load_byte(4'd1, 4'd9, 8'd200);
        evaluate(16'h0001, $urandom);
        load_byte(4'd1, 4'd15, 8'd255);
        evaluate(16'h0001, $urandom);
    endtask

    task automatic test_weighted_pick();
        settle();
        write_reg(CFG_DET_MODE, 16'hFFFE);
        write_reg(CFG_OUTPUT_COUNT, 16'h0002);
        evaluate(16'h0001, 32'd0);
        evaluate(16'h0001, 32'd201);
        evaluate(16'h0001, 32'hFFFF_FFFF);
    endtask

    task automatic test_node_mapping();
        settle();
        write_reg(CFG_INPUT_COUNT, 16'h0004);
        write_reg(CFG_OUTPUT_COUNT, 16'h0004);
        write_reg(CFG_INPUT_MAP, 16'hF05A);
        write_reg(CFG_OUTPUT_MAP, 16'h3333);
        load_byte(4'd15, 4'd15, 8'd254);
        evaluate(16'h8421, $urandom);
        settle();
        write_reg(CFG_OUTPUT_MAP, 16'hFEDC);
        evaluate(16'h8421, $urandom);
    endtask

    task automatic test_spare_registers();
        settle();
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_FIRST_SPARE + CFG_IDX_W'(k), 16'hFFFF);
        end
        evaluate(16'h8421, $urandom);
    endtask

    task automatic test_random_phases();
        int target, phase_items, load_pct, pause_at;
        logic [WEIGHT_W-1:0] wbyte;
        logic [MAP_W-1:0] map;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            settle();
            write_reg(CFG_INPUT_COUNT, ($urandom_range(0, 3) == 0) ?
                      CFG_DAT_W'($urandom_range(0, 1) ? 1 : 4) : CFG_DAT_W'($urandom));
            write_reg(CFG_OUTPUT_COUNT, ($urandom_range(0, 3) == 0) ?
                      CFG_DAT_W'($urandom_range(0, 1) ? 1 : 4) : CFG_DAT_W'($urandom));
            write_reg(CFG_DET_MODE, CFG_DAT_W'($urandom));
            for (int k = 0; k < 2; k++) begin
                case ($urandom_range(0, 3))
                    0: map = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
                    1: map = {4{4'($urandom)}};
                    default: map = MAP_W'($urandom);
                endcase
                write_reg(k == 0 ? CFG_INPUT_MAP : CFG_OUTPUT_MAP, map);
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_FIRST_SPARE + 3'($urandom_range(0, 2)), CFG_DAT_W'($urandom));
            end
            gap_style = $urandom_range(0, 2);
            load_pct = $urandom_range(10, 70);
            phase_items = $urandom_range(20, 150);
            pause_at = ($urandom_range(0, 3) == 0) ? phase_items / 2 : -1;
            for (int k = 0; k < phase_items; k++) begin
                if (k == pause_at) begin
                    drain();
                end
                if ($urandom_range(1, 100) <= load_pct) begin
                    case ($urandom_range(0, 3))
                        0: wbyte = 8'd0;
                        1: wbyte = 8'd255;
                        2: wbyte = WEIGHT_W'($urandom_range(1, 3));
                        default: wbyte = WEIGHT_W'($urandom);
                    endcase
                    load_byte(SIDE_W'($urandom), SIDE_W'($urandom), wbyte);
                end else begin
                    evaluate(MASK_W'($urandom), $urandom);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_gate_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, column %0d mask %h", $time,
                         o_chosen_column, o_set_mask);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_chosen_column !== want.column) begin
                    $display("%0t: chosen_column expected %0d actual %0d", $time,
                             want.column, o_chosen_column);
                    error_count++;
                end
                if (o_set_mask !== want.mask) begin
                    $display("%0t: set_mask expected %h actual %h", $time,
                             want.mask, o_set_mask);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_port_saturation();
        test_deterministic_pick();
        test_weighted_pick();
        test_node_mapping();
        test_spare_registers();
        test_random_phases();
        settle();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
